### rtl/assert_macros.svh
// Assertion helpers used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Implication checked on the next edge
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tmh_pkg.sv
`default_nettype none
package tmh_pkg;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FIRED    = 2'd2;

  // Command beat between the front end and the heap engine
  typedef struct packed {
    logic        kind;
    logic [31:0] duration;
    logic [15:0] dest_port;
    logic [63:0] payload;
  } tmh_cmd_t;

  // Result beat back to the output queue
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fired_port;
    logic [63:0] fired_payload;
    logic        last;
  } tmh_res_t;

  typedef enum logic [3:0] {
    ENG_IDLE,
    ENG_UP_RD,
    ENG_UP_CMP,
    ENG_TOP_RD,
    ENG_TOP_CHK,
    ENG_MV_RD,
    ENG_MV_WR,
    ENG_DN_LEFT,
    ENG_DN_RIGHT,
    ENG_DN_CMP,
    ENG_RES
  } tmh_eng_state_t;

endpackage
`default_nettype wire

### rtl/timer_min_heap_scheduler_unit.sv
`default_nettype none
// Timer min-heap scheduler. Beats pass a two-entry command queue into a heap
// engine with one single-port heap RAM, which handles one beat at a time.
// An add climbs the heap one level at a time (read parent, compare and
// write); a rejected add goes straight to its result. A tick reads the top
// entry and, for every fired timer, moves the last entry to the top and
// sifts it down. Results wait in one output register, so a stalled pop
// holds the engine until the beat is taken.
`include "assert_macros.svh"
module timer_min_heap_scheduler_unit import tmh_pkg::*; #(
  parameter int HEAP_SLOTS = 1024,
  parameter int MAX_FIRES_PER_TICK = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind,
  input  wire logic [31:0] duration,
  input  wire logic [15:0] dest_port,
  input  wire logic [63:0] payload,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [15:0]      fired_port,
  output logic [63:0]      fired_payload,
  output logic             last
);
  tmh_cmd_t in_cmd, cmd;
  tmh_res_t res;
  logic cmd_valid, cmd_take, res_valid;

  assign in_cmd = '{kind: kind, duration: duration, dest_port: dest_port, payload: payload};

  tmh_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  tmh_engine #(.HEAP_SLOTS(HEAP_SLOTS), .MAX_FIRES_PER_TICK(MAX_FIRES_PER_TICK)) u_eng (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .res_valid(res_valid), .res(res), .res_ready(pop)
  );

  assign empty         = !res_valid;
  assign status        = res.status;
  assign fired_port    = res.fired_port;
  assign fired_payload = res.fired_payload;
  assign last          = res.last;

  `ASSERT_CLK(a_status_ok, clk, rst, empty || status == ST_ADDED || status == ST_REJECTED || status == ST_FIRED, "bad status")
  `ASSERT_CLK(a_add_last, clk, rst, empty || status == ST_FIRED || last, "add result without last")
  `ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty, "result beat dropped")
endmodule
`default_nettype wire

### rtl/tmh_ram.sv
`default_nettype none
// Single-port RAM, registered read
module tmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/tmh_front.sv
`default_nettype none
// Input stage: a two-entry command queue in front of the heap engine
module tmh_front import tmh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire tmh_cmd_t in_cmd,
  output logic          cmd_valid,
  output tmh_cmd_t      cmd,
  input  wire logic     cmd_take
);
  tmh_cmd_t   q [2];
  logic [1:0] cnt;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       do_push;
  logic       do_take;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_take) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_take};
    end
  end
endmodule
`default_nettype wire

### rtl/tmh_engine.sv
`default_nettype none
// Heap engine: sift-up for adds, pop and sift-down for ticks
module tmh_engine import tmh_pkg::*; #(
  parameter int HEAP_SLOTS = 1024,
  parameter int MAX_FIRES_PER_TICK = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  input  wire tmh_cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output tmh_res_t      res,
  input  wire logic     res_ready
);
  localparam int AW = $clog2(HEAP_SLOTS);
  localparam int CW = AW + 1;
  localparam int FW = $clog2(MAX_FIRES_PER_TICK + 1);
  localparam int EW = 32 + 16 + 64;
  localparam logic [CW-1:0] SLOTS_C = CW'(HEAP_SLOTS);
  localparam logic [FW-1:0] FMAX_C  = FW'(MAX_FIRES_PER_TICK);

  tmh_eng_state_t state, state_next;

  logic [31:0]   now_ms;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;       // hole position during a sift
  logic [FW-1:0] fires;     // timers popped in this tick
  logic [EW-1:0] cur;       // entry being sifted
  logic [EW-1:0] best;      // left child of the hole
  logic          held;      // fired beat latched, last flag still open
  logic          fire_pend; // another timer is due after the waiting beat

  logic          heap_full;
  logic          up_swap;
  logic          top_due;
  logic [CW-1:0] left_idx;
  logic [CW-1:0] right_idx;
  logic          left_end;
  logic          right_win;
  logic          left_win;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  tmh_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  function automatic logic [31:0] dl(input logic [EW-1:0] e);
    dl = e[EW-1 -: 32];
  endfunction

  // compare terms
  assign heap_full = (entry_count + CW'(1) >= SLOTS_C);
  assign up_swap   = (idx > CW'(1)) && (dl(cur) < dl(rdata));
  assign top_due   = (entry_count != '0) && (fires != FMAX_C) && (dl(rdata) <= now_ms);
  assign left_idx  = {idx[CW-2:0], 1'b0};
  assign right_idx = {idx[CW-2:0], 1'b1};
  assign left_end  = (left_idx > entry_count);
  // right child is checked first, so it wins a tie with the left one
  assign right_win = (right_idx <= entry_count) && (dl(rdata) < dl(cur));
  assign left_win  = right_win ? (dl(best) < dl(rdata)) : (dl(best) < dl(cur));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == KIND_ADD) begin
            state_next = heap_full ? ENG_RES : ENG_UP_RD;
          end else begin
            state_next = ENG_TOP_RD;
          end
        end
      end
      ENG_UP_RD:    state_next = ENG_UP_CMP;
      ENG_UP_CMP:   state_next = up_swap ? ENG_UP_RD : ENG_RES;
      ENG_TOP_RD:   state_next = ENG_TOP_CHK;
      ENG_TOP_CHK: begin
        if (held) state_next = ENG_RES;
        else state_next = top_due ? ENG_MV_RD : ENG_IDLE;
      end
      ENG_MV_RD:    state_next = (entry_count <= CW'(1)) ? ENG_TOP_RD : ENG_MV_WR;
      ENG_MV_WR:    state_next = ENG_DN_LEFT;
      ENG_DN_LEFT:  state_next = left_end ? ENG_TOP_RD : ENG_DN_RIGHT;
      ENG_DN_RIGHT: state_next = ENG_DN_CMP;
      ENG_DN_CMP:   state_next = (left_win || right_win) ? ENG_DN_LEFT : ENG_TOP_RD;
      ENG_RES:      state_next = res_ready ? (fire_pend ? ENG_TOP_RD : ENG_IDLE) : ENG_RES;
      default:      state_next = ENG_IDLE;
    endcase
  end

  // memory port
  always_comb begin
    we    = 1'b0;
    addr  = '0;
    wdata = cur;
    unique case (state)
      ENG_UP_RD:   addr = AW'(idx >> 1);
      ENG_UP_CMP: begin
        we    = 1'b1;
        addr  = AW'(idx);
        wdata = up_swap ? rdata : cur;
      end
      ENG_TOP_RD:  addr = AW'(1);
      ENG_MV_RD:   addr = AW'(entry_count);
      ENG_DN_LEFT: begin
        if (left_end) begin
          we   = 1'b1;
          addr = AW'(idx);
        end else begin
          addr = AW'(left_idx);
        end
      end
      ENG_DN_RIGHT: addr = AW'(right_idx);
      ENG_DN_CMP: begin
        we    = 1'b1;
        addr  = AW'(idx);
        wdata = left_win ? best : (right_win ? rdata : cur);
      end
      default: ;
    endcase
  end

  // handshakes
  assign cmd_take  = (state == ENG_IDLE) && cmd_valid;
  assign res_valid = (state == ENG_RES);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ENG_IDLE;
      now_ms      <= '0;
      entry_count <= '0;
      fires       <= '0;
      held        <= 1'b0;
      fire_pend   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ENG_IDLE: if (cmd_valid) begin
          fires     <= '0;
          held      <= 1'b0;
          fire_pend <= 1'b0;
          if (cmd.kind == KIND_ADD) begin
            cur <= {cmd.duration + now_ms, cmd.dest_port, cmd.payload};
            res <= '{status: heap_full ? ST_REJECTED : ST_ADDED, fired_port: '0,
                     fired_payload: '0, last: 1'b1};
            if (!heap_full) begin
              entry_count <= entry_count + CW'(1);
              idx         <= entry_count + CW'(1);
            end
          end else begin
            now_ms <= now_ms + 32'd1;
          end
        end
        ENG_UP_CMP: if (up_swap) idx <= idx >> 1;
        ENG_TOP_CHK: begin
          if (held) begin
            // the next due timer decides whether the waiting beat is the last
            res.last  <= !top_due;
            fire_pend <= top_due;
            held      <= 1'b0;
          end else if (top_due) begin
            res <= '{status: ST_FIRED, fired_port: rdata[79:64],
                     fired_payload: rdata[63:0], last: 1'b0};
            fires <= fires + FW'(1);
          end
        end
        ENG_MV_RD: begin
          if (entry_count <= CW'(1)) begin
            entry_count <= '0;
            held        <= 1'b1;
          end
        end
        ENG_MV_WR: begin
          cur         <= rdata;
          entry_count <= entry_count - CW'(1);
          idx         <= CW'(1);
        end
        ENG_DN_LEFT:  if (left_end) held <= 1'b1;
        ENG_DN_RIGHT: best <= rdata;
        ENG_DN_CMP: begin
          if (left_win) idx <= left_idx;
          else if (right_win) idx <= right_idx;
          else held <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import tmh_pkg::*;

  // Tracks the timer heap and the queue of results it should produce
  class timer_heap_board;
    bit [31:0]   clock_ms;
    int unsigned count;
    bit [31:0]   due_at [1024];
    bit [15:0]   port_of [1024];
    bit [63:0]   word_of [1024];
    tmh_res_t    due_beats[$];
    int          fails;

    function void clear();
      clock_ms = 0;
      count = 0;
      due_beats.delete();
      fails = 0;
    endfunction

    function void swap_slots(int a, int b);
      bit [31:0] d;
      bit [15:0] p;
      bit [63:0] w;
      d = due_at[a];  p = port_of[a];  w = word_of[a];
      due_at[a] = due_at[b];  port_of[a] = port_of[b];  word_of[a] = word_of[b];
      due_at[b] = d;  port_of[b] = p;  word_of[b] = w;
    endfunction

    function void sift_up(int i);
      while (i > 1 && due_at[i] < due_at[i / 2]) begin
        swap_slots(i, i / 2);
        i = i / 2;
      end
    endfunction

    // right child wins a tie
    function void sift_down(int i);
      int best;
      bit [31:0] bestd;
      while (i >= 1 && i <= count) begin
        best = i;
        bestd = due_at[i];
        if (2 * i + 1 <= count && due_at[2 * i + 1] < bestd) begin
          best = 2 * i + 1;
          bestd = due_at[best];
        end
        if (2 * i <= count && due_at[2 * i] < bestd) best = 2 * i;
        if (best == i) return;
        swap_slots(i, best);
        i = best;
      end
    endfunction

    function void note_beat(bit k, bit [31:0] dur, bit [15:0] dport, bit [63:0] word);
      tmh_res_t r;
      int n;
      n = 0;
      if (k == KIND_ADD) begin
        r = '0;
        r.last = 1'b1;
        if (count + 1 >= 1024) begin
          r.status = ST_REJECTED;
        end else begin
          count++;
          due_at[count] = clock_ms + dur;
          port_of[count] = dport;
          word_of[count] = word;
          sift_up(count);
          r.status = ST_ADDED;
        end
        due_beats.push_back(r);
        return;
      end
      clock_ms = clock_ms + 1;
      while (n < 64 && count > 0 && due_at[1] <= clock_ms) begin
        r.status = ST_FIRED;
        r.fired_port = port_of[1];
        r.fired_payload = word_of[1];
        r.last = 1'b0;
        due_beats.push_back(r);
        if (count <= 1) begin
          count = 0;
        end else begin
          due_at[1] = due_at[count];
          port_of[1] = port_of[count];
          word_of[1] = word_of[count];
          count--;
          sift_down(1);
        end
        n++;
      end
      if (n > 0) due_beats[$].last = 1'b1;
    endfunction

    function void check_beat(tmh_res_t got);
      tmh_res_t want;
      if (due_beats.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = due_beats.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: status %0d/%0d port %h/%h payload %h/%h last %0d/%0d (exp/act)",
                   want.status, got.status, want.fired_port, got.fired_port,
                   want.fired_payload, got.fired_payload, want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        kind = 1'b0;
  logic [31:0] duration = '0;
  logic [15:0] dest_port = '0;
  logic [63:0] payload = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [15:0] fired_port;
  logic [63:0] fired_payload;
  logic        last;

  timer_heap_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  timer_min_heap_scheduler_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .duration(duration), .dest_port(dest_port), .payload(payload),
    .empty(empty), .pop(pop), .status(status), .fired_port(fired_port),
    .fired_payload(fired_payload), .last(last)
  );

  always #5 clk = ~clk;

  // result side: check each popped beat, stall at random
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      board.check_beat('{status: status, fired_port: fired_port,
                         fired_payload: fired_payload, last: last});
    pop <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(bit k, bit [31:0] dur, bit [15:0] dport, bit [63:0] word);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    duration <= dur;
    dest_port <= dport;
    payload <= word;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_beat(k, dur, dport, word);
  endtask

  // hold the sender until every expected beat has arrived
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (board.due_beats.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_beat();
    bit [31:0] dur;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) dur = $urandom();
    else if (pick < 15) dur = 32'hFFFF_FFFF - $urandom_range(3);
    else dur = $urandom_range(20);
    if ($urandom_range(99) < 50)
      send_beat(KIND_ADD, dur, $urandom(), {$urandom(), $urandom()});
    else
      send_beat(KIND_TICK, $urandom(), $urandom(), {$urandom(), $urandom()});
  endtask

  initial begin
    int phase_idle [4] = '{0, 82, 0, 26};
    int phase_stall[4] = '{0, 0, 82, 26};
    board.clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, wrapping deadline, empty tick, tie order
    send_beat(KIND_ADD, 32'd0, 16'h0000, 64'd0);
    send_beat(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1);
    send_beat(KIND_TICK, '0, '0, '0);
    send_beat(KIND_TICK, '1, '1, '1);
    send_beat(KIND_ADD, 32'hFFFF_FFFF, 16'h1234, 64'h0123_4567_89AB_CDEF);
    send_beat(KIND_TICK, '0, '0, '0);
    for (int i = 0; i < 5; i++)
      send_beat(KIND_ADD, 32'd3, 16'(i + 1), 64'(i * 17));
    for (int i = 0; i < 4; i++)
      send_beat(KIND_TICK, '0, '0, '0);
    drain();

    // more timers due at once than the per-tick cap
    for (int i = 0; i < 70; i++)
      send_beat(KIND_ADD, 32'd1, $urandom(), {$urandom(), $urandom()});
    for (int i = 0; i < 3; i++)
      send_beat(KIND_TICK, '0, '0, '0);
    drain();

    // random phases with different idling on each side
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 55; i++) random_beat();
      drain();
    end

    if (board.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
